FILE: sv/pac_pkg.sv
// shared types and constants for the page allocator with compaction
// no dependencies
package pac_pkg;
  localparam int FreeDepth = 32;
  localparam int PageBits  = 24;
  localparam int IdxBits   = $clog2(FreeDepth);
  localparam int CntBits   = $clog2(FreeDepth + 1);

  typedef enum logic [1:0] {
    KIND_GRANT = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_MOVE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [PageBits-1:0] page_id;
  } req_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [PageBits-1:0] granted_page;
    logic [PageBits-1:0] move_from;
    logic [PageBits-1:0] move_to;
    logic                last;
  } rsp_t;
endpackage

FILE: sv/page_allocator_with_compaction.sv
// top level of the page allocator with compaction
// depends on pac_pkg
//
// usage: requests come in on req (valid/stall), results leave on rsp.
// an allocate, a plain free or an error gives one beat; an allocate from
// the list reads the list memory in its own state before the beat, the
// others go straight to the output state.
// a free that brings the list to or above the threshold runs compaction:
// the list of n entries is insertion sorted in place with one compare
// unit over a memory with one write and one read port, then one move
// beat per hole, then the list is rewritten one entry per cycle, then
// the closing beat with last set. only one request is in flight; req
// stall stays high until its last beat is taken.
// reset: empty list, page count one, threshold five; no clearing pass.
// rsp stall holds the beat in the output register and pauses the walk.
// cfg writes take effect at once and belong in idle periods only.
module page_allocator_with_compaction (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_stall_o,
  input  pac_pkg::req_t    req_data_i,
  output logic             rsp_valid_o,
  input  logic             rsp_stall_i,
  output pac_pkg::rsp_t    rsp_data_o,
  input  logic             cfg_we_i,
  input  logic [5:0]       cfg_wdata_i
);
  localparam int PB = pac_pkg::PageBits;
  localparam int IB = pac_pkg::IdxBits;
  localparam int CB = pac_pkg::CntBits;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_ALRD   = 12'b000000000010,
    S_OUT    = 12'b000000000100,
    S_SI     = 12'b000000001000,
    S_SRD    = 12'b000000010000,
    S_SCMP   = 12'b000000100000,
    S_SCHK   = 12'b000001000000,
    S_WRD    = 12'b000010000000,
    S_W2     = 12'b000100000000,
    S_WCHK   = 12'b001000000000,
    S_FILL   = 12'b010000000000,
    S_FIN    = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [PB-1:0] mem [pac_pkg::FreeDepth];
  logic [PB-1:0] rd_q;
  logic          we;
  logic [IB-1:0] wa, ra;
  logic [PB-1:0] wd;

  logic [CB-1:0] fc_q, fc_d, n_q, n_d;
  logic [PB:0]   pc_q, pc_d;
  logic [5:0]    thr_q;
  logic [CB-1:0] i_q, i_d, j_q, j_d, i1_q, i1_d, i2_q, i2_d;
  logic [PB-1:0] v_q, v_d;
  logic [PB:0]   slot_q, slot_d, de_q, de_d;
  pac_pkg::rsp_t rsp_q, rsp_d;
  logic          ret_q, ret_d;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  // shared compare
  logic [PB:0] ca, cb;
  logic        lt;
  assign lt = ca < cb;

  logic acc;
  assign acc = req_valid_i && !req_stall_o;
  assign req_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q; fc_d = fc_q; pc_d = pc_q; n_d = n_q;
    i_d = i_q; j_d = j_q; i1_d = i1_q; i2_d = i2_q; v_d = v_q;
    slot_d = slot_q; de_d = de_q; rsp_d = rsp_q; ret_d = ret_q;
    we = 1'b0; wa = '0; wd = '0; ra = '0;
    ca = '0; cb = '0;
    case (state_q)
      S_IDLE: if (acc) begin
        rsp_d = '0;
        rsp_d.last = 1'b1;
        ret_d = 1'b0;
        if (req_data_i.opcode == pac_pkg::OP_ALLOC) begin
          rsp_d.kind = pac_pkg::KIND_GRANT;
          if (fc_q != 0) begin
            fc_d = fc_q - 1'b1;
            ra = IB'(fc_q - 1'b1);
            state_d = S_ALRD;
          end else if (!pc_q[PB]) begin
            rsp_d.granted_page = pc_q[PB-1:0];
            pc_d = pc_q + 1'b1;
            state_d = S_OUT;
          end else begin
            rsp_d.kind = pac_pkg::KIND_ERROR;
            state_d = S_OUT;
          end
        end else if (fc_q >= CB'(pac_pkg::FreeDepth)) begin
          rsp_d.kind = pac_pkg::KIND_ERROR;
          state_d = S_OUT;
        end else begin
          we = 1'b1; wa = IB'(fc_q); wd = req_data_i.page_id;
          fc_d = fc_q + 1'b1;
          rsp_d.kind = pac_pkg::KIND_FREE;
          if (CB'(fc_q + 1'b1) >= CB'(thr_q)) begin
            n_d = fc_q + 1'b1;
            i_d = CB'(1);
            state_d = S_SI;
          end else state_d = S_OUT;
        end
      end
      S_ALRD: begin
        rsp_d.granted_page = rd_q;
        state_d = S_OUT;
      end
      S_OUT: if (!rsp_stall_i) begin
        if (ret_q) begin
          ret_d = 1'b0;
          state_d = S_W2;
        end else state_d = S_IDLE;
      end
      S_SI: begin
        if (i_q >= n_q) begin
          ca = pc_q; cb = (PB+1)'(n_q);
          de_d = lt ? '0 : pc_q - (PB+1)'(n_q);
          i2_d = '0; i1_d = '0;
          state_d = S_WRD;
        end else begin
          ra = IB'(i_q);
          j_d = i_q;
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        v_d = rd_q;
        ra = IB'(j_q - 1'b1);
        state_d = S_SCMP;
      end
      S_SCMP: begin
        ca = {1'b0, v_q}; cb = {1'b0, rd_q};
        if (j_q != 0 && lt) begin
          we = 1'b1; wa = IB'(j_q); wd = rd_q;
          j_d = j_q - 1'b1;
          state_d = S_SCHK;
        end else begin
          we = 1'b1; wa = IB'(j_q); wd = v_q;
          i_d = i_q + 1'b1;
          state_d = S_SI;
        end
      end
      S_SCHK: begin
        if (j_q == 0) begin
          we = 1'b1; wa = '0; wd = v_q;
          i_d = i_q + 1'b1;
          state_d = S_SI;
        end else begin
          ra = IB'(j_q - 1'b1);
          state_d = S_SCMP;
        end
      end
      // skip list entries below the boundary, then set slot
      S_WRD: begin
        ra = IB'(i2_q);
        state_d = S_WCHK;
      end
      S_WCHK: begin
        ca = {1'b0, rd_q}; cb = de_q;
        if (i2_q < n_q && lt) begin
          i2_d = i2_q + 1'b1;
          state_d = S_WRD;
        end else begin
          slot_d = de_q;
          state_d = S_W2;
        end
      end
      // move walk: read list[i2] then list[i1]
      S_W2: begin
        if (i2_q < n_q) begin
          ra = IB'(i2_q);
          i_d = '0;
          state_d = S_FIN;
        end else begin
          ra = IB'(i1_q);
          i_d = CB'(1);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (i_q == 0) begin
          if (rd_q == slot_q[PB-1:0] && !slot_q[PB]) begin
            i2_d = i2_q + 1'b1;
            slot_d = slot_q + 1'b1;
            state_d = S_W2;
          end else begin
            ra = IB'(i1_q);
            i_d = CB'(1);
          end
        end else begin
          ca = {1'b0, rd_q}; cb = de_q;
          if (i1_q < n_q && lt) begin
            rsp_d = '0;
            rsp_d.kind = pac_pkg::KIND_MOVE;
            rsp_d.move_from = slot_q[PB-1:0];
            rsp_d.move_to = rd_q;
            i1_d = i1_q + 1'b1;
            slot_d = slot_q + 1'b1;
            ret_d = 1'b1;
            state_d = S_OUT;
          end else begin
            fc_d = CB'(pc_q - de_q);
            i_d = '0;
            state_d = S_FILL;
          end
        end
      end
      S_FILL: begin
        if (i_q < fc_q) begin
          we = 1'b1; wa = IB'(i_q); wd = PB'(de_q + (PB+1)'(i_q));
          i_d = i_q + 1'b1;
        end else begin
          rsp_d = '0;
          rsp_d.kind = pac_pkg::KIND_FREE;
          rsp_d.last = 1'b1;
          state_d = S_OUT;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_OUT && ret_q == 1'b0 && rsp_stall_i) state_d = S_OUT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; fc_q <= '0; pc_q <= (PB+1)'(1); thr_q <= 6'd5; ret_q <= 1'b0;
      i_q <= '0; j_q <= '0; i1_q <= '0; i2_q <= '0; n_q <= '0;
    end else begin
      state_q <= state_d; fc_q <= fc_d; pc_q <= pc_d; ret_q <= ret_d;
      i_q <= i_d; j_q <= j_d; i1_q <= i1_d; i2_q <= i2_d; n_q <= n_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d; v_q <= v_d; slot_q <= slot_d; de_q <= de_d;
  end

  assign rsp_valid_o = state_q == S_OUT;
  assign rsp_data_o  = rsp_q;

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= CB'(pac_pkg::FreeDepth)) else $error("free count overflow");
  a_mv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_data_o.kind == pac_pkg::KIND_MOVE |-> !rsp_data_o.last)
    else $error("move marked last");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> req_stall_o) else $error("ready while result pending");
  a_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q != '0) else $error("page count zero");
endmodule
